// File: rtl/bpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial probability core package
// Shared widths, fixed-point constants, result word type and the reciprocal
// table used for exact division in the coefficient loop.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int MAX_TRIALS = 20;
  localparam int FRAC_BITS  = 16;

  localparam int CNT_W     = 5;
  localparam int PROB_W    = FRAC_BITS + 1;
  localparam int COEF_W    = 18;
  localparam int DIV_SHIFT = 22;
  localparam int DIV_W     = DIV_SHIFT + 1;
  localparam int MUL_W     = (PROB_W > DIV_W) ? PROB_W : DIV_W;
  localparam int PROD_W    = 2 * MUL_W;

  localparam logic [PROB_W-1:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic [COEF_W-1:0] coefficient;
    logic              invalid;
  } res_t;

  // ceil(2^DIV_SHIFT / d); exact for quotients of dividends below 2^DIV_SHIFT
  function automatic logic [MUL_W-1:0] recip(input logic [CNT_W-1:0] d);
    logic [MUL_W-1:0] r;
    unique case (d)
      5'd1:    r = MUL_W'(4194304);
      5'd2:    r = MUL_W'(2097152);
      5'd3:    r = MUL_W'(1398102);
      5'd4:    r = MUL_W'(1048576);
      5'd5:    r = MUL_W'(838861);
      5'd6:    r = MUL_W'(699051);
      5'd7:    r = MUL_W'(599187);
      5'd8:    r = MUL_W'(524288);
      5'd9:    r = MUL_W'(466034);
      5'd10:   r = MUL_W'(419431);
      5'd11:   r = MUL_W'(381301);
      5'd12:   r = MUL_W'(349526);
      5'd13:   r = MUL_W'(322639);
      5'd14:   r = MUL_W'(299594);
      5'd15:   r = MUL_W'(279621);
      5'd16:   r = MUL_W'(262144);
      5'd17:   r = MUL_W'(246724);
      5'd18:   r = MUL_W'(233017);
      5'd19:   r = MUL_W'(220753);
      5'd20:   r = MUL_W'(209716);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/binomial_probability_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial probability core
// Exact C(n,k) and C(n,k) * p^k * (1-p)^(n-k) in unsigned Q1.16.
// ----------------------------------------------------------------------------
// One item is worked at a time on a single registered multiplier: the
// coefficient loop spends two multiplies per step (product, then exact
// division through a reciprocal), each power one per step, then one for the
// product of the powers and one for the scale. An item with k above n or n
// above 20 returns invalid with zero payload. The result sits in an output
// register, so the next item is taken while the previous word waits.
module binomial_probability_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [bpc_pkg::CNT_W-1:0]  trials,
  input  logic [bpc_pkg::CNT_W-1:0]  successes,
  input  logic [bpc_pkg::PROB_W-1:0] success_prob,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [bpc_pkg::PROB_W-1:0] probability,
  output logic [bpc_pkg::COEF_W-1:0] coefficient,
  output logic                       invalid
);
  import bpc_pkg::*;

  logic res_valid;
  res_t res;
  logic out_free;

  assign out_free = !rsp_valid || !rsp_stall;

  bpc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .trials       (trials),
    .successes    (successes),
    .success_prob (success_prob),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (out_free)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      probability <= res.probability;
      coefficient <= res.coefficient;
      invalid     <= res.invalid;
    end
  end

endmodule

// File: rtl/bpc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned multiplier with a registered product, loaded when enabled.
// ----------------------------------------------------------------------------
module bpc_mul (
  input  logic                       clk,
  input  logic                       en,
  input  logic [bpc_pkg::MUL_W-1:0]  a,
  input  logic [bpc_pkg::MUL_W-1:0]  b,
  output logic [bpc_pkg::PROD_W-1:0] p
);
  import bpc_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

// File: rtl/bpc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial probability sequencer
// Runs the coefficient loop, both power loops, the final product and the
// saturating scale on the shared multiplier.
// ----------------------------------------------------------------------------
module bpc_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [bpc_pkg::CNT_W-1:0] trials,
  input  logic [bpc_pkg::CNT_W-1:0] successes,
  input  logic [bpc_pkg::PROB_W-1:0] success_prob,
  output logic                      res_valid,
  output bpc_pkg::res_t             res,
  input  logic                      res_take
);
  import bpc_pkg::*;

  typedef enum logic [3:0] {
    IDLE, SETUP, CH_MUL, CH_DIV, PW_P, PW_Q, PROD, SCALE, DONE
  } state_t;

  state_t             state;
  logic               phase;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   nk;
  logic [PROB_W-1:0]  p;
  logic [PROB_W-1:0]  q;
  logic [COEF_W-1:0]  coef;
  logic [PROB_W-1:0]  acc_p;
  logic [PROB_W-1:0]  acc_q;
  logic [PROB_W-1:0]  pq;

  logic [CNT_W-1:0]   cnt_inc;
  logic [PROB_W-1:0]  p_sat;
  logic               bad_in;
  state_t             after_ch;
  state_t             after_pp;
  logic [MUL_W-1:0]   op_a;
  logic [MUL_W-1:0]   op_b;
  logic [PROD_W-1:0]  mprod;
  logic [PROB_W-1:0]  mfrac;

  assign cnt_inc   = cnt + 1'b1;
  assign p_sat     = (success_prob > Q_ONE) ? Q_ONE : success_prob;
  assign bad_in    = (trials > CNT_W'(MAX_TRIALS)) || (successes > trials);
  assign after_pp  = (nk != '0) ? PW_Q : PROD;
  assign after_ch  = (k != '0) ? PW_P : after_pp;
  assign mfrac     = mprod[FRAC_BITS +: PROB_W];
  assign req_stall = (state != IDLE);
  assign res_valid = (state == DONE);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      CH_MUL: begin
        op_a = MUL_W'(coef);
        op_b = MUL_W'(n - cnt);
      end
      CH_DIV: begin
        op_a = MUL_W'(mprod[DIV_SHIFT-1:0]);
        op_b = recip(cnt_inc);
      end
      PW_P: begin
        op_a = MUL_W'(acc_p);
        op_b = MUL_W'(p);
      end
      PW_Q: begin
        op_a = MUL_W'(acc_q);
        op_b = MUL_W'(q);
      end
      PROD: begin
        op_a = MUL_W'(acc_p);
        op_b = MUL_W'(acc_q);
      end
      SCALE: begin
        op_a = MUL_W'(coef);
        op_b = MUL_W'(pq);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  bpc_mul u_mul (
    .clk (clk),
    .en  (~phase),
    .a   (op_a),
    .b   (op_b),
    .p   (mprod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          phase <= 1'b0;
          cnt   <= '0;
          if (req_valid) begin
            n     <= trials;
            k     <= successes;
            nk    <= trials - successes;
            p     <= p_sat;
            q     <= Q_ONE - p_sat;
            coef  <= COEF_W'(1);
            acc_p <= Q_ONE;
            acc_q <= Q_ONE;
            if (bad_in) begin
              res.probability <= '0;
              res.coefficient <= '0;
              res.invalid     <= 1'b1;
              state           <= DONE;
            end else begin
              state <= SETUP;
            end
          end
        end
        SETUP: begin
          state <= (k != '0) ? CH_MUL : after_ch;
        end
        CH_MUL: begin
          phase <= ~phase;
          if (phase) begin
            state <= CH_DIV;
          end
        end
        CH_DIV: begin
          phase <= ~phase;
          if (phase) begin
            coef <= mprod[DIV_SHIFT +: COEF_W];
            if (cnt_inc < k) begin
              cnt   <= cnt_inc;
              state <= CH_MUL;
            end else begin
              cnt   <= '0;
              state <= after_ch;
            end
          end
        end
        PW_P: begin
          phase <= ~phase;
          if (phase) begin
            acc_p <= mfrac;
            if (cnt_inc < k) begin
              cnt <= cnt_inc;
            end else begin
              cnt   <= '0;
              state <= after_pp;
            end
          end
        end
        PW_Q: begin
          phase <= ~phase;
          if (phase) begin
            acc_q <= mfrac;
            if (cnt_inc < nk) begin
              cnt <= cnt_inc;
            end else begin
              cnt   <= '0;
              state <= PROD;
            end
          end
        end
        PROD: begin
          phase <= ~phase;
          if (phase) begin
            pq    <= mfrac;
            state <= SCALE;
          end
        end
        SCALE: begin
          phase <= ~phase;
          if (phase) begin
            res.probability <= (mprod > PROD_W'(Q_ONE)) ? Q_ONE : mprod[PROB_W-1:0];
            res.coefficient <= coef;
            res.invalid     <= 1'b0;
            state           <= DONE;
          end
        end
        DONE: begin
          if (res_take) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    res_valid && res.invalid |-> res.probability == '0 && res.coefficient == '0)
    else $error("invalid word carries nonzero payload");

  a_prob_sat : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.probability <= Q_ONE)
    else $error("probability above one");

  a_ch_count : assert property (@(posedge clk) disable iff (rst)
    state == CH_MUL || state == CH_DIV |-> cnt < k)
    else $error("coefficient loop overran successes");

  a_q_count : assert property (@(posedge clk) disable iff (rst)
    state == PW_Q |-> cnt < nk)
    else $error("failure power loop overran");

  a_done_hold : assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_take |=> res_valid && $stable(res))
    else $error("finished word lost before handoff");

endmodule
